@@ sv/homogeneous_vector_transform_4x4_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 4x4 homogeneous vector transform
// Shared by every file that carries concurrent checks on the block.
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_VECTOR_TRANSFORM_4X4_TOP_DEFINES_SVH
`define HOMOGENEOUS_VECTOR_TRANSFORM_4X4_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define HVT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define HVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/hvt_pkg.sv @@
// ----------------------------------------------------------------------------
// hvt_pkg
// Constants and helpers shared by the 4x4 vector transform files.
// ----------------------------------------------------------------------------
`default_nettype none

package hvt_pkg;

    localparam int IO_BITS      = 32;  // width of every vector and result field
    localparam int HALF_BITS    = 32;  // coefficient slot inside a register
    localparam int REG_BITS     = 64;  // configuration register width
    localparam int NUM_REGS     = 8;
    localparam int REG_IDX_BITS = 3;
    localparam int CFG_IDX_BITS = 4;   // index port, one spare bit for ignored writes
    localparam int DIM          = 4;

    // Reset value of one matrix register: identity with 1.0 = 1 << frac.
    function automatic logic [REG_BITS-1:0] mat_reset(input int idx, input int frac);
        logic [REG_BITS-1:0] one;
        int                  row;
        int                  pair;
        one  = REG_BITS'(1) << frac;
        row  = idx >> 1;
        pair = idx & 1;
        if (pair != (row >> 1))
            return '0;
        else if ((row & 1) != 0)
            return one << HALF_BITS;
        else
            return one;
    endfunction

endpackage

`default_nettype wire

@@ sv/hvt_vec_in_if.sv @@
// ----------------------------------------------------------------------------
// hvt_vec_in_if
// Input vector channel: valid/ready handshake and four signed components.
// ----------------------------------------------------------------------------
`default_nettype none

interface hvt_vec_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [hvt_pkg::IO_BITS-1:0]  x_in;
    logic signed [hvt_pkg::IO_BITS-1:0]  y_in;
    logic signed [hvt_pkg::IO_BITS-1:0]  z_in;
    logic signed [hvt_pkg::IO_BITS-1:0]  w_in;

    modport source (output valid, x_in, y_in, z_in, w_in, input ready);
    modport sink   (input valid, x_in, y_in, z_in, w_in, output ready);
endinterface

`default_nettype wire

@@ sv/hvt_vec_out_if.sv @@
// ----------------------------------------------------------------------------
// hvt_vec_out_if
// Result channel: valid/ready handshake, four components and a clamp flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface hvt_vec_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [hvt_pkg::IO_BITS-1:0]  x_out;
    logic signed [hvt_pkg::IO_BITS-1:0]  y_out;
    logic signed [hvt_pkg::IO_BITS-1:0]  z_out;
    logic signed [hvt_pkg::IO_BITS-1:0]  w_out;
    logic                                saturated;

    modport source (output valid, x_out, y_out, z_out, w_out, saturated, input ready);
    modport sink   (input valid, x_out, y_out, z_out, w_out, saturated, output ready);
endinterface

`default_nettype wire

@@ sv/hvt_mul.sv @@
// ----------------------------------------------------------------------------
// hvt_mul
// Stage 1: sixteen exact coefficient-by-component products, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_mul #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        up_valid,
    output      logic                        up_ready,
    input  wire logic signed [WORD_BITS-1:0] vec  [hvt_pkg::DIM],
    input  wire logic signed [WORD_BITS-1:0] coef [hvt_pkg::DIM][hvt_pkg::DIM],
    output      logic                        dn_valid,
    input  wire logic                        dn_ready,
    output      logic signed [2*WORD_BITS-1:0] prod [hvt_pkg::DIM][hvt_pkg::DIM]
);

    localparam int PROD_BITS = 2 * WORD_BITS;

    logic                        valid_reg;
    logic                        valid_next;
    logic signed [PROD_BITS-1:0] prod_reg  [hvt_pkg::DIM][hvt_pkg::DIM];
    logic signed [PROD_BITS-1:0] prod_next [hvt_pkg::DIM][hvt_pkg::DIM];

    // Advance when the stage is empty or its content moves on.
    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_comb
    begin
        for (int r = 0; r < hvt_pkg::DIM; r++)
        begin
            for (int c = 0; c < hvt_pkg::DIM; c++)
            begin
                prod_next[r][c] = PROD_BITS'(coef[r][c]) * PROD_BITS'(vec[c]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            prod_reg <= prod_next;
    end

    assign dn_valid = valid_reg;
    assign prod     = prod_reg;

endmodule

`default_nettype wire

@@ sv/hvt_sum.sv @@
// ----------------------------------------------------------------------------
// hvt_sum
// Stage 2: add the products of each row in pairs at full width.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_sum #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          up_valid,
    output      logic                          up_ready,
    input  wire logic signed [2*WORD_BITS-1:0] prod [hvt_pkg::DIM][hvt_pkg::DIM],
    output      logic                          dn_valid,
    input  wire logic                          dn_ready,
    output      logic signed [2*WORD_BITS:0]   pair [hvt_pkg::DIM][2]
);

    localparam int PAIR_BITS = 2 * WORD_BITS + 1;

    logic                        valid_reg;
    logic                        valid_next;
    logic signed [PAIR_BITS-1:0] pair_reg  [hvt_pkg::DIM][2];
    logic signed [PAIR_BITS-1:0] pair_next [hvt_pkg::DIM][2];

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_comb
    begin
        for (int r = 0; r < hvt_pkg::DIM; r++)
        begin
            for (int p = 0; p < 2; p++)
            begin
                pair_next[r][p] = PAIR_BITS'(prod[r][2*p]) + PAIR_BITS'(prod[r][2*p+1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            pair_reg <= pair_next;
    end

    assign dn_valid = valid_reg;
    assign pair     = pair_reg;

endmodule

`default_nettype wire

@@ sv/hvt_sat.sv @@
// ----------------------------------------------------------------------------
// hvt_sat
// Stage 3: final row sum, floor shift, clamp to the word range; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_sat #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               up_valid,
    output      logic                               up_ready,
    input  wire logic signed [2*WORD_BITS:0]        pair [hvt_pkg::DIM][2],
    output      logic                               dn_valid,
    input  wire logic                               dn_ready,
    output      logic signed [hvt_pkg::IO_BITS-1:0] res  [hvt_pkg::DIM],
    output      logic                               sat
);

    localparam int SUM_BITS = 2 * WORD_BITS + 2;
    localparam logic signed [SUM_BITS-1:0] MAXV =
        (SUM_BITS'(1) <<< (WORD_BITS - 1)) - SUM_BITS'(1);
    localparam logic signed [SUM_BITS-1:0] MINV = -MAXV - SUM_BITS'(1);

    logic                               valid_reg;
    logic                               valid_next;
    logic signed [hvt_pkg::IO_BITS-1:0] res_reg  [hvt_pkg::DIM];
    logic signed [hvt_pkg::IO_BITS-1:0] res_next [hvt_pkg::DIM];
    logic                               sat_reg;
    logic                               sat_next;
    logic signed [SUM_BITS-1:0]         total    [hvt_pkg::DIM];
    logic signed [SUM_BITS-1:0]         shifted  [hvt_pkg::DIM];
    logic signed [WORD_BITS-1:0]        clamped  [hvt_pkg::DIM];

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_comb
    begin
        sat_next = 1'b0;
        for (int r = 0; r < hvt_pkg::DIM; r++)
        begin
            total[r]   = SUM_BITS'(pair[r][0]) + SUM_BITS'(pair[r][1]);
            // arithmetic shift floors toward minus infinity
            shifted[r] = total[r] >>> FRAC_BITS;
            if (shifted[r] > MAXV)
            begin
                clamped[r] = WORD_BITS'(MAXV);
                sat_next   = 1'b1;
            end
            else if (shifted[r] < MINV)
            begin
                clamped[r] = WORD_BITS'(MINV);
                sat_next   = 1'b1;
            end
            else
            begin
                clamped[r] = WORD_BITS'(shifted[r]);
            end
            res_next[r] = hvt_pkg::IO_BITS'(clamped[r]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign dn_valid = valid_reg;
    assign res      = res_reg;
    assign sat      = sat_reg;

endmodule

`default_nettype wire

@@ sv/homogeneous_vector_transform_4x4_top.sv @@
// ----------------------------------------------------------------------------
// homogeneous_vector_transform_4x4_top
// 4x4 fixed-point matrix times homogeneous vector, one vector per clock while res.ready is high.
// ----------------------------------------------------------------------------
//
//   channel   role      handshake             payload
//   -------   -------   -------------------   -------------------------------
//   vec       sink      vec.valid/vec.ready   x_in, y_in, z_in, w_in
//   res       source    res.valid/res.ready   x_out..w_out, saturated
//   cfg       write     cfg_we                cfg_index, cfg_data (64 bits)
//
// Throughput is one vector per clock while res.ready is high. The accepting
// edge loads the first of three register stages (multiply, pair add, and
// final add with shift and clamp, which is the output register), and the
// vector then moves through them in that order as each next stage frees.
// Reset clears the stage valid bits and loads the identity matrix.
// Each stage holds its transaction while the next one is full and stalled,
// so empty stages still fill and vec.ready stays high whenever res.ready is.
// ----------------------------------------------------------------------------
`default_nettype none

module homogeneous_vector_transform_4x4_top #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    hvt_vec_in_if.sink                             vec,
    hvt_vec_out_if.source                          res,
    input  wire logic                              cfg_we,
    input  wire logic [hvt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [hvt_pkg::REG_BITS-1:0]      cfg_data
);

    localparam int DIM = hvt_pkg::DIM;

    // Matrix registers: written at the addressed index, read at fixed slots.
    logic [hvt_pkg::REG_BITS-1:0]  mat_reg [hvt_pkg::NUM_REGS];

    logic signed [WORD_BITS-1:0]   vec_w   [DIM];
    logic signed [WORD_BITS-1:0]   coef    [DIM][DIM];

    logic                          s1_valid;
    logic                          s1_ready;
    logic signed [2*WORD_BITS-1:0] s1_prod [DIM][DIM];
    logic                          s2_valid;
    logic                          s2_ready;
    logic signed [2*WORD_BITS:0]   s2_pair [DIM][2];
    logic signed [hvt_pkg::IO_BITS-1:0] s3_res [DIM];

    // Drop writes beyond the register list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hvt_pkg::NUM_REGS; i++)
            begin
                mat_reg[i] <= hvt_pkg::mat_reset(i, FRAC_BITS);
            end
        end
        else if (cfg_we && (cfg_index < hvt_pkg::CFG_IDX_BITS'(hvt_pkg::NUM_REGS)))
        begin
            mat_reg[cfg_index[hvt_pkg::REG_IDX_BITS-1:0]] <= cfg_data;
        end
    end

    // Coefficient M[r][c] sits in register 2r + c/2, low half for even c.
    // Only the low WORD_BITS of each slot count.
    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                coef[r][c] = mat_reg[2*r + (c >> 1)][(c & 1)*hvt_pkg::HALF_BITS +: WORD_BITS];
            end
        end
    end

    // Only the low WORD_BITS of each input component count.
    assign vec_w[0] = vec.x_in[WORD_BITS-1:0];
    assign vec_w[1] = vec.y_in[WORD_BITS-1:0];
    assign vec_w[2] = vec.z_in[WORD_BITS-1:0];
    assign vec_w[3] = vec.w_in[WORD_BITS-1:0];

    // Stage 1: products.
    hvt_mul #(
        .WORD_BITS (WORD_BITS)
    ) u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (vec.valid),
        .up_ready (vec.ready),
        .vec      (vec_w),
        .coef     (coef),
        .dn_valid (s1_valid),
        .dn_ready (s1_ready),
        .prod     (s1_prod)
    );

    // Stage 2: pair sums.
    hvt_sum #(
        .WORD_BITS (WORD_BITS)
    ) u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .prod     (s1_prod),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .pair     (s2_pair)
    );

    // Stage 3: row sum, floor shift, clamp; holds the result transaction.
    hvt_sat #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_sat (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s2_ready),
        .pair     (s2_pair),
        .dn_valid (res.valid),
        .dn_ready (res.ready),
        .res      (s3_res),
        .sat      (res.saturated)
    );

    assign res.x_out = s3_res[0];
    assign res.y_out = s3_res[1];
    assign res.z_out = s3_res[2];
    assign res.w_out = s3_res[3];

endmodule

`default_nettype wire

@@ sv/hvt_check.sv @@
// ----------------------------------------------------------------------------
// hvt_check
// Port-level checks on the vector transform, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "homogeneous_vector_transform_4x4_top_defines.svh"

module hvt_check #(
    parameter int WORD_BITS = 32
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_ready,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic signed [hvt_pkg::IO_BITS-1:0] x_out,
    input wire logic signed [hvt_pkg::IO_BITS-1:0] y_out,
    input wire logic signed [hvt_pkg::IO_BITS-1:0] z_out,
    input wire logic signed [hvt_pkg::IO_BITS-1:0] w_out,
    input wire logic                               saturated
);

    localparam logic signed [hvt_pkg::IO_BITS-1:0] MAXV =
        (hvt_pkg::IO_BITS'(1) <<< (WORD_BITS - 1)) - hvt_pkg::IO_BITS'(1);
    localparam logic signed [hvt_pkg::IO_BITS-1:0] MINV = -MAXV - hvt_pkg::IO_BITS'(1);

    logic in_acc;
    logic clamp_hit;

    assign in_acc    = in_valid && in_ready;
    assign clamp_hit = (x_out == MAXV) || (x_out == MINV) || (y_out == MAXV) ||
                       (y_out == MINV) || (z_out == MAXV) || (z_out == MINV) ||
                       (w_out == MAXV) || (w_out == MINV);

    // A stalled result transaction holds.
    `HVT_ASSERT_NEXT(a_res_hold, out_valid && !out_ready,
        out_valid && $stable({x_out, y_out, z_out, w_out, saturated}),
        "stalled result changed")

    // A draining output never backs up the input.
    `HVT_ASSERT_NOW(a_no_stall_when_drained, out_ready, in_ready,
        "input stalled while output is taken")

    // A clamp flag comes with at least one component at a range limit.
    `HVT_ASSERT_NOW(a_sat_limit, out_valid && saturated, clamp_hit,
        "saturated set with no clamped component")

    // With the output draining throughout, no result emerges for an idle input cycle.
    `HVT_ASSERT_NEXT(a_no_phantom,
        out_ready && $past(out_ready) && $past(out_ready, 2) && !$past(in_acc, 2),
        !out_valid, "result without a matching input")

endmodule

bind homogeneous_vector_transform_4x4_top hvt_check #(
    .WORD_BITS (WORD_BITS)
) u_hvt_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vec.valid),
    .in_ready  (vec.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .x_out     (res.x_out),
    .y_out     (res.y_out),
    .z_out     (res.z_out),
    .w_out     (res.w_out),
    .saturated (res.saturated)
);

`default_nettype wire
